### design/rqf_pkg.sv
// Shared widths, codes, types and helpers for the read quality filter.
package rqf_pkg;

    localparam int QUALITY_W = 7;
    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 23;
    localparam int WTOTAL_W  = 13;
    localparam int WSIZE_W   = 7;
    localparam int PTR_W     = 6;
    localparam int FRAC_W    = 17;
    localparam int MODE_W    = 2;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam int MAX_READ_LENGTH = 65535;
    localparam int MAX_WINDOW      = 64;

    localparam logic [MODE_W-1:0] MODE_AVERAGE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINGLE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WINDOW     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PROPORTION = 2'd3;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_WINDOW    = 2'd2;
    localparam logic [1:0] REG_FRACTION  = 2'd3;

    localparam logic [MODE_W-1:0]    RESET_MODE      = MODE_AVERAGE;
    localparam logic [QUALITY_W-1:0] RESET_THRESHOLD = 7'd20;
    localparam logic [WSIZE_W-1:0]   RESET_WINDOW    = 7'd4;
    localparam logic [FRAC_W-1:0]    RESET_FRACTION  = 17'd32768;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [QUALITY_W-1:0] thr;
        logic [WSIZE_W-1:0]   win;
        logic [FRAC_W-1:0]    frac;
    } cfg_t;

    // Per-read totals handed from the accumulator to the verdict stage
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [QUALITY_W-1:0] thr;
        logic [FRAC_W-1:0]    frac;
        logic [COUNT_W-1:0]   len;
        logic [TOTAL_W-1:0]   total;
        logic [COUNT_W-1:0]   passing;
        logic                 low_seen;
        logic                 trim_found;
        logic [COUNT_W-1:0]   trim_len;
        logic [WSIZE_W-1:0]   active_w;
    } snap_t;

    function automatic logic [WSIZE_W-1:0] clamp_window(input logic [WSIZE_W-1:0] w);
        logic [WSIZE_W-1:0] r;
        if (w == '0)
            r = WSIZE_W'(1);
        else if (w > WSIZE_W'(MAX_WINDOW))
            r = WSIZE_W'(MAX_WINDOW);
        else
            r = w;
        return r;
    endfunction

endpackage

### design/rqf_in_if.sv
// Base quality channel: one base per item.
interface rqf_in_if;
    import rqf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [QUALITY_W-1:0] quality;
    logic                 last_base;

    modport source (output valid, quality, last_base, input ready);
    modport sink (input valid, quality, last_base, output ready);
    modport monitor (input valid, ready, quality, last_base);
endinterface

### design/rqf_out_if.sv
// Verdict channel: one item per read.
interface rqf_out_if;
    import rqf_pkg::*;

    logic               valid;
    logic               ready;
    logic               keep;
    logic [COUNT_W-1:0] keep_length;

    modport source (output valid, keep, keep_length, input ready);
    modport sink (input valid, keep, keep_length, output ready);
    modport monitor (input valid, ready, keep, keep_length);
endinterface

### design/rqf_cfg.sv
// APB register bank holding mode, threshold, window size and fraction.
module rqf_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqf_pkg::ADDR_W-1:0] paddr,
    input  logic [rqf_pkg::DATA_W-1:0] pwdata,
    output logic [rqf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rqf_pkg::cfg_t              cfg
);
    import rqf_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= RESET_MODE;
            cfg_reg.thr  <= RESET_THRESHOLD;
            cfg_reg.win  <= RESET_WINDOW;
            cfg_reg.frac <= RESET_FRACTION;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:      cfg_reg.mode <= pwdata[MODE_W-1:0];
                REG_THRESHOLD: cfg_reg.thr  <= pwdata[QUALITY_W-1:0];
                REG_WINDOW:    cfg_reg.win  <= pwdata[WSIZE_W-1:0];
                REG_FRACTION:  cfg_reg.frac <= pwdata[FRAC_W-1:0];
                default:       cfg_reg      <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:      prdata = DATA_W'(cfg_reg.mode);
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.thr);
            REG_WINDOW:    prdata = DATA_W'(cfg_reg.win);
            REG_FRACTION:  prdata = DATA_W'(cfg_reg.frac);
            default:       prdata = '0;
        endcase
    end
endmodule

### design/rqf_accum.sv
// Per-read accumulator: running sums, sliding window store and snapshot register.
module rqf_accum (
    input  logic           clk,
    input  logic           rst_n,
    input  rqf_pkg::cfg_t  cfg,
    rqf_in_if.sink         bases,
    output rqf_pkg::snap_t snap,
    output logic           snap_valid,
    input  logic           snap_take
);
    import rqf_pkg::*;

    logic [QUALITY_W-1:0] win_mem [MAX_WINDOW];

    logic [COUNT_W-1:0]   count_reg, count_upd;
    logic [TOTAL_W-1:0]   total_reg, total_upd;
    logic [WTOTAL_W-1:0]  wtotal_reg, wtotal_upd;
    logic [COUNT_W-1:0]   passing_reg, passing_upd;
    logic                 low_reg, low_upd;
    logic                 found_reg, found_upd;
    logic [COUNT_W-1:0]   trim_reg, trim_upd;
    logic [PTR_W-1:0]     ptr_reg, ptr_upd, ptr_next;
    logic [WSIZE_W-1:0]   active_reg, active_upd;
    logic                 snap_valid_reg;
    snap_t                snap_reg;

    logic [QUALITY_W-1:0] rd_data_reg, fwd_data_reg, old_q;
    logic                 fwd_reg;

    logic                 accept, take, done, filling, fail, pass_q;
    logic [QUALITY_W-1:0] q;
    logic [WSIZE_W-1:0]   w;
    logic [WTOTAL_W-1:0]  thr_w, wt_new;
    logic [WSIZE_W-1:0]   ptr_plus;

    assign bases.ready = !snap_valid_reg || snap_take;
    assign accept      = bases.valid && bases.ready;
    assign done        = accept && bases.last_base;
    assign take        = accept && (count_reg != COUNT_W'(MAX_READ_LENGTH));
    assign q           = bases.quality;

    // Latch the window length on the first base of a read
    assign w        = (count_reg == '0) ? clamp_window(cfg.win) : active_reg;
    assign thr_w    = WTOTAL_W'(cfg.thr) * WTOTAL_W'(w);
    assign filling  = count_reg < COUNT_W'(w);
    assign old_q    = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign pass_q   = q >= cfg.thr;
    assign wt_new   = filling ? (wtotal_reg + WTOTAL_W'(q))
                              : (wtotal_reg - WTOTAL_W'(old_q) + WTOTAL_W'(q));
    assign fail     = !found_reg && (wt_new < thr_w)
                      && (!filling || (count_reg == COUNT_W'(w - WSIZE_W'(1))));
    assign ptr_plus = {1'b0, ptr_reg} + WSIZE_W'(1);

    always_comb
    begin
        count_upd   = count_reg;
        total_upd   = total_reg;
        wtotal_upd  = wtotal_reg;
        passing_upd = passing_reg;
        low_upd     = low_reg;
        found_upd   = found_reg;
        trim_upd    = trim_reg;
        ptr_upd     = ptr_reg;
        active_upd  = active_reg;
        if (take)
        begin
            count_upd   = count_reg + COUNT_W'(1);
            total_upd   = total_reg + TOTAL_W'(q);
            wtotal_upd  = wt_new;
            passing_upd = passing_reg + COUNT_W'(pass_q);
            low_upd     = low_reg || !pass_q;
            active_upd  = w;
            ptr_upd     = (ptr_plus >= w) ? '0 : ptr_plus[PTR_W-1:0];
            if (fail)
            begin
                found_upd = 1'b1;
                trim_upd  = filling ? '0 : count_reg;
            end
        end
    end

    assign ptr_next = done ? '0 : ptr_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            wtotal_reg  <= '0;
            passing_reg <= '0;
            low_reg     <= 1'b0;
            found_reg   <= 1'b0;
            trim_reg    <= '0;
            ptr_reg     <= '0;
            active_reg  <= WSIZE_W'(1);
            fwd_reg     <= 1'b0;
        end
        else
        begin
            fwd_reg <= take && (ptr_next == ptr_reg);
            if (done)
            begin
                // Clear for the next read
                count_reg   <= '0;
                total_reg   <= '0;
                wtotal_reg  <= '0;
                passing_reg <= '0;
                low_reg     <= 1'b0;
                found_reg   <= 1'b0;
                trim_reg    <= '0;
                ptr_reg     <= '0;
                active_reg  <= WSIZE_W'(1);
            end
            else
            begin
                count_reg   <= count_upd;
                total_reg   <= total_upd;
                wtotal_reg  <= wtotal_upd;
                passing_reg <= passing_upd;
                low_reg     <= low_upd;
                found_reg   <= found_upd;
                trim_reg    <= trim_upd;
                ptr_reg     <= ptr_upd;
                active_reg  <= active_upd;
            end
        end
    end

    // Window store: prefetch the entry the next base will replace
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            win_mem[ptr_reg] <= q;
        end
        rd_data_reg  <= win_mem[ptr_next];
        fwd_data_reg <= q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            snap_reg.mode       <= cfg.mode;
            snap_reg.thr        <= cfg.thr;
            snap_reg.frac       <= cfg.frac;
            snap_reg.len        <= count_upd;
            snap_reg.total      <= total_upd;
            snap_reg.passing    <= passing_upd;
            snap_reg.low_seen   <= low_upd;
            snap_reg.trim_found <= found_upd;
            snap_reg.trim_len   <= trim_upd;
            snap_reg.active_w   <= active_upd;
        end
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;
endmodule

### design/rqf_verdict.sv
// Verdict stage: judge the finished read by mode and register the result item.
module rqf_verdict (
    input  logic           clk,
    input  logic           rst_n,
    input  rqf_pkg::snap_t snap,
    input  logic           snap_valid,
    output logic           snap_take,
    rqf_out_if.source      verdicts
);
    import rqf_pkg::*;

    logic                 valid_reg;
    logic                 keep_reg;
    logic [COUNT_W-1:0]   length_reg;
    logic                 out_free;
    logic [TOTAL_W-1:0]   thr_len;
    logic [FRAC_W+COUNT_W-1:0] frac_len;
    logic [FRAC_W+COUNT_W-1:0] pass_scaled;
    logic                 avg_ok;
    logic [COUNT_W-1:0]   kept;

    assign out_free  = !valid_reg || verdicts.ready;
    assign snap_take = snap_valid && out_free;

    assign thr_len     = TOTAL_W'(snap.thr) * TOTAL_W'(snap.len);
    assign frac_len    = (FRAC_W+COUNT_W)'(snap.frac) * (FRAC_W+COUNT_W)'(snap.len);
    assign pass_scaled = {1'b0, snap.passing, 16'b0};
    assign avg_ok      = snap.total >= thr_len;

    always_comb
    begin
        unique case (snap.mode)
            MODE_AVERAGE:
                kept = avg_ok ? snap.len : '0;
            MODE_SINGLE:
                kept = snap.low_seen ? '0 : snap.len;
            MODE_WINDOW:
            begin
                if (snap.trim_found)
                    kept = snap.trim_len;
                else if (snap.len < COUNT_W'(snap.active_w))
                    kept = avg_ok ? snap.len : '0;
                else
                    kept = snap.len;
            end
            MODE_PROPORTION:
                kept = (pass_scaled >= frac_len) ? snap.len : '0;
            default:
                kept = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= snap_take || (valid_reg && !verdicts.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            keep_reg   <= kept != '0;
            length_reg <= kept;
        end
    end

    assign verdicts.valid       = valid_reg;
    assign verdicts.keep        = keep_reg;
    assign verdicts.keep_length = length_reg;
endmodule

### design/read_quality_filter_top.sv
// Top level of the read quality filter.
// Throughput: one base item per cycle, sustained, while the verdict side keeps up.
// After the last base is accepted, the verdict item passes the snapshot register and then the
// output register before it is offered.
// One further read can wait in the snapshot register while a verdict is stalled.
// Reset clears counters, handshake and config state; the window store is filled before use.
module read_quality_filter_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqf_pkg::ADDR_W-1:0] paddr,
    input  logic [rqf_pkg::DATA_W-1:0] pwdata,
    output logic [rqf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    rqf_in_if.sink                     bases,
    rqf_out_if.source                  verdicts
);
    import rqf_pkg::*;

    cfg_t  cfg;
    snap_t snap;
    logic  snap_valid;
    logic  snap_take;

    rqf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rqf_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .bases      (bases),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_take  (snap_take)
    );

    rqf_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .verdicts   (verdicts)
    );
endmodule

### design/rqf_checker.sv
// Port-level checks for the read quality filter, bound to the top level.
module rqf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        base_valid,
    input  logic                        base_ready,
    input  logic                        base_last,
    input  logic                        verdict_valid,
    input  logic                        verdict_ready,
    input  logic                        verdict_keep,
    input  logic [rqf_pkg::COUNT_W-1:0] verdict_length
);

    // A stalled verdict stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && !verdict_ready) |=> verdict_valid)
        else $error("verdict dropped while stalled");

    a_keep_length: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict_keep == (verdict_length != '0)))
        else $error("keep disagrees with kept length");

    // Last base into an empty pipe gives a verdict through the snapshot and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (base_valid && base_ready && base_last && !verdict_valid)
        |=> ##1 verdict_valid)
        else $error("verdict late for read into empty pipe");

    // Hold off bases only when a verdict is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !base_ready |-> (verdict_valid && !verdict_ready))
        else $error("input stalled without a waiting verdict");
endmodule

bind read_quality_filter_top rqf_checker u_rqf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .base_valid     (bases.valid),
    .base_ready     (bases.ready),
    .base_last      (bases.last_base),
    .verdict_valid  (verdicts.valid),
    .verdict_ready  (verdicts.ready),
    .verdict_keep   (verdicts.keep),
    .verdict_length (verdicts.keep_length)
);
